// ===== hw/rtl/tto_pkg.sv =====
// ----------------------------------------------------------------------------
// tto_pkg
// Shared constants, codes and types of the one-shot / periodic timer table.
// ----------------------------------------------------------------------------
package tto_pkg;

    // table geometry
    localparam int NUM_TIMERS  = 16;
    localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // field widths
    localparam int CMD_W   = 3;
    localparam int KIND_W  = 2;
    localparam int ID_W    = 32;
    localparam int DELAY_W = 32;
    localparam int TIME_W  = 64;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ONESHOT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PERIODIC = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CANCEL   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_SCHED  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } tto_state_t;

endpackage

// ===== hw/rtl/tto_req_if.sv =====
// ----------------------------------------------------------------------------
// tto_req_if
// Command channel of the timer table: valid/ready plus one command item.
// ----------------------------------------------------------------------------
interface tto_req_if
    import tto_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [DELAY_W-1:0] delay_ticks;
    logic [ID_W-1:0]    target_id;

    modport source (output valid, output cmd, output delay_ticks, output target_id,
                    input ready);
    modport sink   (input valid, input cmd, input delay_ticks, input target_id,
                    output ready);
endinterface

// ===== hw/rtl/tto_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tto_rsp_if
// Result channel of the timer table: valid/ready plus one result item.
// ----------------------------------------------------------------------------
interface tto_rsp_if
    import tto_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   timer_id;
    logic              ok;
    logic              last;

    modport source (output valid, output kind, output timer_id, output ok, output last,
                    input ready);
    modport sink   (input valid, input kind, input timer_id, input ok, input last,
                    output ready);
endinterface

// ===== hw/rtl/timer_table_oneshot_periodic.sv =====
// Schedule and cancel run one full scan of the table before their result; clear goes
// straight to the done step. A tick runs one full scan of the table through the single
// compare unit per fired entry, plus one empty scan.
// Throughput: one item at a time; ready is high only while the sequencer is idle.
// Reset: table emptied, time at zero, next id at one; entry contents are left as is.
// ----------------------------------------------------------------------------
// timer_table_oneshot_periodic
// Table of one-shot and periodic timers driven by tick, schedule, cancel and
// clear items. One scan index walks the table entry by entry through a shared
// compare unit; one 64-bit adder forms all due times.
// ----------------------------------------------------------------------------
module timer_table_oneshot_periodic
    import tto_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tto_req_if.sink    req,
    tto_rsp_if.source  rsp
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    // control state
    tto_state_t             state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg;
    logic                   hit_reg;
    logic                   free_reg;
    logic                   pend_reg;
    logic [CNT_W-1:0]       fire_cnt_reg;
    logic [NUM_TIMERS-1:0]  fired_reg;
    logic [NUM_TIMERS-1:0]  entry_valid_reg;
    logic [TIME_W-1:0]      now_reg;
    logic [ID_W-1:0]        next_id_reg;
    logic                   rsp_valid_reg;

    // item and scan payload
    logic [CMD_W-1:0]       cmd_reg;
    logic [DELAY_W-1:0]     delay_reg;
    logic [ID_W-1:0]        target_reg;
    logic [IDX_W-1:0]       hit_idx_reg;
    logic [ID_W-1:0]        hit_id_reg;
    logic [IDX_W-1:0]       free_idx_reg;
    logic [ID_W-1:0]        pend_id_reg;

    // table storage
    logic [ID_W-1:0]        entry_id_reg     [NUM_TIMERS];
    logic [TIME_W-1:0]      entry_due_reg    [NUM_TIMERS];
    logic [DELAY_W-1:0]     entry_period_reg [NUM_TIMERS];
    logic                   entry_repeats_reg[NUM_TIMERS];

    // output register payload
    logic [KIND_W-1:0]      rsp_kind_reg;
    logic [ID_W-1:0]        rsp_id_reg;
    logic                   rsp_ok_reg;
    logic                   rsp_last_reg;

    // combinational
    logic                   accept;
    logic                   out_free;
    logic [ID_W-1:0]        scan_id;
    logic [ID_W-1:0]        key_id;
    logic                   scan_valid;
    logic                   id_eq;
    logic                   id_lt;
    logic                   due_le;
    logic                   scan_take;
    logic                   scan_free;
    logic [DELAY_W-1:0]     add_b;
    logic [TIME_W-1:0]      sum;
    logic [ID_W-1:0]        next_id_inc;
    logic [ID_W-1:0]        next_id_wrap;
    logic                   fire;
    logic                   slot_ok;
    logic [IDX_W-1:0]       slot_idx;
    logic                   need_emit;
    logic                   advance;
    logic [KIND_W-1:0]      emit_kind;
    logic [ID_W-1:0]        emit_id;
    logic                   emit_ok;
    logic                   emit_last;

    // handshake
    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign out_free  = !rsp_valid_reg || rsp.ready;

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.kind     = rsp_kind_reg;
    assign rsp.timer_id = rsp_id_reg;
    assign rsp.ok       = rsp_ok_reg;
    assign rsp.last     = rsp_last_reg;

    // shared compare unit on the scanned entry
    assign scan_id    = entry_id_reg[idx_reg];
    assign scan_valid = entry_valid_reg[idx_reg];
    assign key_id     = (cmd_reg == CMD_CANCEL) ? target_reg : next_id_reg;
    assign id_eq      = (scan_id == key_id);
    assign id_lt      = (scan_id < hit_id_reg);
    assign due_le     = (entry_due_reg[idx_reg] <= now_reg);

    always_comb
    begin
        scan_take = 1'b0;
        scan_free = 1'b0;
        unique case (cmd_reg)
            CMD_TICK:
            begin
                scan_take = scan_valid && !fired_reg[idx_reg] && due_le
                            && (!hit_reg || id_lt);
            end
            CMD_ONESHOT, CMD_PERIODIC:
            begin
                scan_take = scan_valid && id_eq && !hit_reg;
                scan_free = !scan_valid && !free_reg;
            end
            CMD_CANCEL:
            begin
                scan_take = scan_valid && id_eq && !hit_reg && (target_reg != '0);
            end
            default:
            begin
                scan_take = 1'b0;
            end
        endcase
    end

    // shared time adder: tick increment, new due time or reschedule
    always_comb
    begin
        if (state_reg == ST_IDLE)
            add_b = DELAY_W'(1);
        else if (cmd_reg == CMD_TICK)
            add_b = entry_period_reg[hit_idx_reg];
        else
            add_b = delay_reg;
    end

    assign sum          = now_reg + TIME_W'(add_b);
    assign next_id_inc  = next_id_reg + ID_W'(1);
    assign next_id_wrap = (next_id_inc == '0) ? ID_W'(1) : next_id_inc;

    assign fire     = hit_reg && (fire_cnt_reg != CNT_W'(MAX_RESULTS));
    assign slot_ok  = hit_reg || free_reg;
    assign slot_idx = hit_reg ? hit_idx_reg : free_idx_reg;

    // result selection in the done step
    always_comb
    begin
        need_emit = 1'b1;
        emit_kind = KIND_CLEAR;
        emit_id   = '0;
        emit_ok   = 1'b0;
        emit_last = 1'b1;
        unique case (cmd_reg)
            CMD_TICK:
            begin
                need_emit = pend_reg;
                emit_kind = KIND_FIRED;
                emit_id   = pend_id_reg;
                emit_ok   = 1'b1;
                emit_last = !fire;
            end
            CMD_ONESHOT, CMD_PERIODIC:
            begin
                emit_kind = KIND_SCHED;
                emit_id   = slot_ok ? next_id_reg : '0;
                emit_ok   = slot_ok;
            end
            CMD_CANCEL:
            begin
                emit_kind = KIND_CANCEL;
                emit_id   = target_reg;
                emit_ok   = hit_reg;
            end
            default:
            begin
                emit_kind = KIND_CLEAR;
            end
        endcase
        advance = (state_reg == ST_DONE) && (!need_emit || out_free);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.cmd == CMD_TICK || req.cmd == CMD_ONESHOT ||
                        req.cmd == CMD_PERIODIC || req.cmd == CMD_CANCEL)
                        state_next = ST_SCAN;
                    else if (req.cmd == CMD_CLEAR)
                        state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (advance)
                    state_next = (cmd_reg == CMD_TICK && fire) ? ST_SCAN : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            hit_reg         <= 1'b0;
            free_reg        <= 1'b0;
            pend_reg        <= 1'b0;
            fire_cnt_reg    <= '0;
            fired_reg       <= '0;
            entry_valid_reg <= '0;
            now_reg         <= '0;
            next_id_reg     <= ID_W'(1);
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // new item
            if (accept)
            begin
                idx_reg      <= '0;
                hit_reg      <= 1'b0;
                free_reg     <= 1'b0;
                pend_reg     <= 1'b0;
                fire_cnt_reg <= '0;
                fired_reg    <= '0;
                if (req.cmd == CMD_TICK)
                    now_reg <= sum;
            end

            // scan step
            if (state_reg == ST_SCAN)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (scan_take)
                    hit_reg <= 1'b1;
                if (scan_free)
                    free_reg <= 1'b1;
            end

            // done step
            if (advance)
            begin
                unique case (cmd_reg)
                    CMD_TICK:
                    begin
                        if (fire)
                        begin
                            fired_reg[hit_idx_reg] <= 1'b1;
                            if (!entry_repeats_reg[hit_idx_reg])
                                entry_valid_reg[hit_idx_reg] <= 1'b0;
                            pend_reg     <= 1'b1;
                            fire_cnt_reg <= fire_cnt_reg + CNT_W'(1);
                            idx_reg      <= '0;
                            hit_reg      <= 1'b0;
                        end
                        else
                        begin
                            pend_reg <= 1'b0;
                        end
                    end
                    CMD_ONESHOT, CMD_PERIODIC:
                    begin
                        if (slot_ok)
                        begin
                            entry_valid_reg[slot_idx] <= 1'b1;
                            next_id_reg               <= next_id_wrap;
                        end
                    end
                    CMD_CANCEL:
                    begin
                        if (hit_reg)
                            entry_valid_reg[hit_idx_reg] <= 1'b0;
                    end
                    default:
                    begin
                        entry_valid_reg <= '0;
                    end
                endcase
            end

            // output register
            if (advance && need_emit)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // payload registers and table storage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= req.cmd;
            delay_reg  <= req.delay_ticks;
            target_reg <= req.target_id;
        end

        if (state_reg == ST_SCAN)
        begin
            if (scan_take)
            begin
                hit_idx_reg <= idx_reg;
                hit_id_reg  <= scan_id;
            end
            if (scan_free)
                free_idx_reg <= idx_reg;
        end

        if (advance)
        begin
            if (cmd_reg == CMD_TICK && fire)
            begin
                pend_id_reg <= hit_id_reg;
                if (entry_repeats_reg[hit_idx_reg])
                    entry_due_reg[hit_idx_reg] <= sum;
            end
            else if ((cmd_reg == CMD_ONESHOT || cmd_reg == CMD_PERIODIC) && slot_ok)
            begin
                entry_id_reg[slot_idx]      <= next_id_reg;
                entry_due_reg[slot_idx]     <= sum;
                entry_period_reg[slot_idx]  <= (cmd_reg == CMD_PERIODIC) ? delay_reg : '0;
                entry_repeats_reg[slot_idx] <= (cmd_reg == CMD_PERIODIC);
            end
        end

        if (advance && need_emit)
        begin
            rsp_kind_reg <= emit_kind;
            rsp_id_reg   <= emit_id;
            rsp_ok_reg   <= emit_ok;
            rsp_last_reg <= emit_last;
        end
    end

    // checks
    a_next_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        next_id_reg != '0)
        else $error("next id reached zero");

    a_scan_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && idx_reg != LAST_IDX)
        |=> (state_reg == ST_SCAN && idx_reg == IDX_W'($past(idx_reg) + IDX_W'(1))))
        else $error("scan index did not advance");

    a_tick_advances_time: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.cmd == CMD_TICK) |=> now_reg == $past(now_reg) + TIME_W'(1))
        else $error("tick did not advance time");

    a_only_fired_continue: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_last_reg) |-> rsp_kind_reg == KIND_FIRED)
        else $error("non-last item that is not a fired timer");

    a_pend_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && state_reg != ST_IDLE) |-> cmd_reg == CMD_TICK)
        else $error("held fire result outside a tick");

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the one-shot / periodic timer table. A queue of
// command items feeds a valid/ready driver, and a monitor checks every result
// item against a cycle-free model of the table that is updated on each accepted
// command. The run has a directed opening, then a long random mix. Sender and
// receiver idling change between phases.
// ----------------------------------------------------------------------------
module testbench;
    import tto_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_CMDS  = 295;
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [DELAY_W-1:0] delay_ticks;
        logic [ID_W-1:0]    target_id;
    } timer_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   timer_id;
        logic              ok;
        logic              last;
    } timer_evt_t;

    logic clk;
    logic rst_n;

    tto_req_if req_ch ();
    tto_rsp_if rsp_ch ();

    timer_table_oneshot_periodic u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow copy of the table
    logic [TIME_W-1:0]  now_ms;
    logic [ID_W-1:0]    id_counter;
    bit                 slot_used     [NUM_TIMERS];
    logic [ID_W-1:0]    slot_id       [NUM_TIMERS];
    logic [TIME_W-1:0]  slot_due      [NUM_TIMERS];
    logic [DELAY_W-1:0] slot_period   [NUM_TIMERS];
    bit                 slot_periodic [NUM_TIMERS];

    timer_cmd_t pending_cmds[$];
    timer_evt_t awaited_events[$];

    int  cmd_total;
    int  cmds_done;
    bit  cmd_taken;
    int  mismatch_count;
    int  cycle_count;
    int  ids_issued;

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // apply one accepted command to the shadow table and queue its results
    task automatic apply_to_table(input timer_cmd_t c);
        timer_evt_t batch [MAX_RESULTS];
        bit         fired [NUM_TIMERS];
        int         n;
        int         best;
        int         slot;
        bit         found;
        n = 0;
        case (c.cmd)
            CMD_TICK:
            begin
                now_ms = now_ms + 1;
                for (int i = 0; i < NUM_TIMERS; i++)
                    fired[i] = 1'b0;
                best = 0;
                // fire due entries, smallest id first
                while (n < MAX_RESULTS && best >= 0)
                begin
                    best = -1;
                    for (int i = 0; i < NUM_TIMERS; i++)
                    begin
                        if (slot_used[i] && !fired[i] && slot_due[i] <= now_ms)
                        begin
                            if (best < 0 || slot_id[i] < slot_id[best])
                                best = i;
                        end
                    end
                    if (best >= 0)
                    begin
                        fired[best] = 1'b1;
                        batch[n] = '{KIND_FIRED, slot_id[best], 1'b1, 1'b0};
                        n++;
                        if (slot_periodic[best])
                            slot_due[best] = now_ms + TIME_W'(slot_period[best]);
                        else
                            slot_used[best] = 1'b0;
                    end
                end
            end
            CMD_ONESHOT, CMD_PERIODIC:
            begin
                // same id in place first, else lowest free slot
                slot = -1;
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (slot < 0 && slot_used[i] && slot_id[i] == id_counter)
                        slot = i;
                end
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (slot < 0 && !slot_used[i])
                        slot = i;
                end
                if (slot < 0)
                begin
                    batch[0] = '{KIND_SCHED, {ID_W{1'b0}}, 1'b0, 1'b0};
                end
                else
                begin
                    slot_used[slot]     = 1'b1;
                    slot_id[slot]       = id_counter;
                    slot_due[slot]      = now_ms + TIME_W'(c.delay_ticks);
                    slot_periodic[slot] = (c.cmd == CMD_PERIODIC);
                    slot_period[slot]   = (c.cmd == CMD_PERIODIC) ? c.delay_ticks : '0;
                    batch[0] = '{KIND_SCHED, id_counter, 1'b1, 1'b0};
                    id_counter = id_counter + 1;
                    if (id_counter == '0)
                        id_counter = 1;
                end
                n = 1;
            end
            CMD_CANCEL:
            begin
                found = 1'b0;
                if (c.target_id != '0)
                begin
                    for (int i = 0; i < NUM_TIMERS; i++)
                    begin
                        if (!found && slot_used[i] && slot_id[i] == c.target_id)
                        begin
                            slot_used[i] = 1'b0;
                            found = 1'b1;
                        end
                    end
                end
                batch[0] = '{KIND_CANCEL, c.target_id, found, 1'b0};
                n = 1;
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                    slot_used[i] = 1'b0;
                batch[0] = '{KIND_CLEAR, {ID_W{1'b0}}, 1'b0, 1'b0};
                n = 1;
            end
            default:
            begin
                // undefined codes change nothing
            end
        endcase
        for (int i = 0; i < n; i++)
        begin
            batch[i].last = (i == n - 1);
            awaited_events.insert(awaited_events.size(), batch[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [ID_W-1:0] want,
                               input logic [ID_W-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic add_cmd(input logic [CMD_W-1:0] cmd, input logic [DELAY_W-1:0] dly,
                           input logic [ID_W-1:0] tgt);
        pending_cmds.insert(pending_cmds.size(), '{cmd, dly, tgt});
        if (cmd == CMD_ONESHOT || cmd == CMD_PERIODIC)
            ids_issued++;
    endtask

    // monitor: check result items, then model accepted command items
    always @(posedge clk)
    begin : watch_channels
        timer_evt_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_events.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual kind %0d id %0h",
                             $time, rsp_ch.kind, rsp_ch.timer_id);
                end
                else
                begin
                    want = awaited_events.pop_front();
                    check_field("kind", ID_W'(want.kind), ID_W'(rsp_ch.kind));
                    check_field("timer_id", want.timer_id, rsp_ch.timer_id);
                    check_field("ok", ID_W'(want.ok), ID_W'(rsp_ch.ok));
                    check_field("last", ID_W'(want.last), ID_W'(rsp_ch.last));
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                apply_to_table('{req_ch.cmd, req_ch.delay_ticks, req_ch.target_id});
                cmd_taken = 1'b1;
            end
        end
    end

    // driver and receiver stalls, changed at the falling edge
    always @(negedge clk)
    begin : drive_channels
        int  phase;
        int  send_idle;
        int  recv_idle;
        bit  popped;
        if (rst_n)
        begin
            popped = 1'b0;
            if (cmd_taken)
            begin
                void'(pending_cmds.pop_front());
                cmds_done++;
                cmd_taken = 1'b0;
                popped = 1'b1;
            end
            phase = (cmds_done * 3) / cmd_total;
            send_idle = (phase == 0) ? 25 : (phase == 1) ? 58 : 0;
            recv_idle = (phase == 0) ? 58 : (phase == 1) ? 25 : 0;
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
            // hold an item until it is taken
            if (!req_ch.valid || popped)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    req_ch.valid       <= 1'b1;
                    req_ch.cmd         <= pending_cmds[0].cmd;
                    req_ch.delay_ticks <= pending_cmds[0].delay_ticks;
                    req_ch.target_id   <= pending_cmds[0].target_id;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : run
        int pick;
        int made;
        int lo;
        bit wide;
        logic [CMD_W-1:0] cmd;

        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.cmd         = CMD_TICK;
        req_ch.delay_ticks = '0;
        req_ch.target_id   = '0;
        rsp_ch.ready       = 1'b0;
        now_ms             = '0;
        id_counter         = 1;
        for (int i = 0; i < NUM_TIMERS; i++)
            slot_used[i] = 1'b0;
        cmds_done      = 0;
        cmd_taken      = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        ids_issued     = 0;

        // directed: empty table, zero delays, cancels, full table, mass fire
        add_cmd(CMD_CLEAR, '0, '0);
        add_cmd(CMD_CANCEL, '0, '0);
        add_cmd(CMD_TICK, '0, '0);
        add_cmd(CMD_ONESHOT, '0, '0);
        add_cmd(CMD_PERIODIC, '0, '0);
        add_cmd(CMD_TICK, '0, '0);
        add_cmd(CMD_TICK, '0, '0);
        add_cmd(CMD_CANCEL, '0, 32'd2);
        add_cmd(CMD_CANCEL, '0, 32'd2);
        add_cmd(CMD_ONESHOT, 32'hFFFF_FFFF, '0);
        add_cmd(CMD_PERIODIC, 32'd3, '0);
        add_cmd(CMD_CANCEL, '0, 32'hFFFF_FFFF);
        for (int i = 0; i < 14; i++)
            add_cmd(CMD_ONESHOT, '0, '0);
        add_cmd(CMD_ONESHOT, 32'd5, '0);
        add_cmd(CMD_TICK, '0, '0);
        add_cmd(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_cmd(3'd7, '0, '0);
        add_cmd(CMD_CLEAR, '0, '0);

        // random mix, ignored codes not counted
        made = 0;
        while (made < RANDOM_CMDS)
        begin
            pick = $urandom_range(0, 99);
            wide = ($urandom_range(0, 9) == 0);
            if (pick < 40)
            begin
                add_cmd(CMD_TICK, $urandom, $urandom);
                made++;
            end
            else if (pick < 60)
            begin
                add_cmd(CMD_ONESHOT, wide ? $urandom : $urandom_range(0, 6), $urandom);
                made++;
            end
            else if (pick < 72)
            begin
                add_cmd(CMD_PERIODIC, wide ? $urandom : $urandom_range(0, 8), $urandom);
                made++;
            end
            else if (pick < 92)
            begin
                // mostly recently issued ids
                lo = (ids_issued > 7) ? ids_issued - 6 : 1;
                add_cmd(CMD_CANCEL, $urandom,
                        wide ? $urandom : $urandom_range(lo, ids_issued + 1));
                made++;
            end
            else if (pick < 96)
            begin
                add_cmd(CMD_CLEAR, $urandom, $urandom);
                made++;
            end
            else
            begin
                cmd = CMD_W'($urandom_range(5, 7));
                add_cmd(cmd, $urandom, $urandom);
            end
        end
        cmd_total = pending_cmds.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for all items and results, then let the block settle
        while (pending_cmds.size() != 0)
            @(posedge clk);
        while (awaited_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && awaited_events.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== timer_table_oneshot_periodic.f =====
hw/rtl/tto_pkg.sv
hw/rtl/tto_req_if.sv
hw/rtl/tto_rsp_if.sv
hw/rtl/timer_table_oneshot_periodic.sv
tb/sv/testbench.sv
